// File: rtl/hv2d_pkg.sv
// ----------------------------------------------------------------------------
// hv2d_pkg
// Shared types, constants and helpers for the 2D hypervolume sweep block.
// ----------------------------------------------------------------------------
package hv2d_pkg;

    localparam int COORD_BITS     = 24;
    localparam int DIFF_BITS      = COORD_BITS + 1;
    localparam int PROD_BITS      = 2 * DIFF_BITS;
    localparam int VOL_BITS       = 63;
    localparam int IDX_BITS       = 8;
    localparam int DEF_MAX_POINTS = 256;

    localparam logic [VOL_BITS-1:0] VOL_MAX = {VOL_BITS{1'b1}};

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic [DIFF_BITS-1:0]         diff_t;
    typedef logic [PROD_BITS-1:0]         prod_t;

    typedef struct packed {
        coord_t point_x;
        coord_t point_y;
        logic   last_point;
    } in_item_t;

    typedef struct packed {
        logic [VOL_BITS-1:0] volume;
        logic [IDX_BITS-1:0] contributor_index;
    } out_item_t;

    typedef enum logic [1:0] {
        CFG_REF_X   = 2'd0,
        CFG_REF_Y   = 2'd1,
        CFG_MODE    = 2'd2,
        CFG_PRESORT = 2'd3
    } cfg_idx_t;

    typedef enum logic [1:0] {
        MODE_TOTAL    = 2'd0,
        MODE_LEAST    = 2'd1,
        MODE_GREATEST = 2'd2
    } mode_t;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_DISPATCH,
        ST_RANK_FETCH,
        ST_RANK_LATCH,
        ST_RANK_SCAN,
        ST_RANK_WRITE,
        ST_SW_ORD,
        ST_SW_PT,
        ST_SW_DAT,
        ST_SW_MUL,
        ST_SW_ACC,
        ST_SW_ADV,
        ST_SW_FIN,
        ST_EMIT
    } state_t;

    // |a - b| of two coordinates
    function automatic diff_t adiff(input coord_t a, input coord_t b);
        logic signed [DIFF_BITS-1:0] d;
        d = DIFF_BITS'(a) - DIFF_BITS'(b);
        return d[DIFF_BITS-1] ? diff_t'(-d) : diff_t'(d);
    endfunction

endpackage

// File: rtl/hypervolume_2d_with_contributor.sv
// ----------------------------------------------------------------------------
// hypervolume_2d_with_contributor
// 2D hypervolume sweep with least / greatest exclusive contributor search.
// ----------------------------------------------------------------------------
// Usage:
//   in_*   : one point per transaction; last_point closes the set. Points are
//            taken one per cycle while loading; beyond MAX_POINTS they drop.
//   out_*  : one result per closed set (volume or contributor_index).
//   cfg_*  : register writes (ref_x, ref_y, mode, presort), always ready;
//            write only while the block is idle.
// Work after the closing point, n points in the set:
//   sort (presort in mode 0, in modes 1 and 2 when n >= 2): a
//   rank count that scans the y store once per point over its single port.
//   sweep: each point goes through the shared 25x25 multiplier,
//   with dispatch before and emit after.
// in_ready is low from the closing point until the result is registered.
// The output register holds a result while the receiver stalls; loading of
// the next set goes on meanwhile, and its result waits for the slot.
// Reset clears control state and loads register defaults (presort = 1).
// ----------------------------------------------------------------------------
module hypervolume_2d_with_contributor #(
    parameter int MAX_POINTS = hv2d_pkg::DEF_MAX_POINTS
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  hv2d_pkg::in_item_t   in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output hv2d_pkg::out_item_t  out_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  hv2d_pkg::cfg_idx_t   cfg_index,
    input  hv2d_pkg::coord_t     cfg_data
);
    import hv2d_pkg::*;

    localparam int AW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);

    // configuration
    coord_t       ref_x_reg, ref_y_reg;
    logic [1:0]   mode_reg;
    logic         presort_reg;

    state_t       state_reg, state_next;

    coord_t       x_mem [MAX_POINTS];
    coord_t       y_mem [MAX_POINTS];
    logic [AW-1:0] ord_mem [MAX_POINTS];

    coord_t        x_rd_reg, y_rd_reg;
    logic [AW-1:0] ord_rd_reg;
    logic [AW-1:0] pt_addr;

    logic [CW-1:0] cnt_reg, n_reg, i_reg, j_reg, k_reg;
    logic [AW-1:0] rank_reg;
    coord_t        yi_reg;
    logic          use_ord_reg, desc_reg, fin_reg;

    coord_t        xp_reg, yp_reg, yp2_reg;
    logic [AW-1:0] pidx_reg, pa_reg;
    diff_t         opa_reg, opb_reg;
    prod_t         prod_reg;
    logic [VOL_BITS-1:0] acc_reg;
    prod_t         best_value_reg;
    logic [AW-1:0] best_idx_reg;

    logic          out_valid_reg;
    out_item_t     out_data_reg;

    logic          load_fire, last_scan, hit, greatest, better;
    logic [VOL_BITS:0] sum;
    logic [CW-1:0] j_inc;
    logic [AW+IDX_BITS-1:0] idx_ext;

    assign load_fire = in_valid && in_ready;
    assign last_scan = (j_reg == n_reg - CW'(1));
    assign j_inc     = j_reg + CW'(1);
    assign greatest  = (mode_reg == MODE_GREATEST);
    assign better    = greatest ? (prod_reg > best_value_reg) : (prod_reg < best_value_reg);
    assign sum       = {1'b0, acc_reg} + (VOL_BITS+1)'(prod_reg);
    assign idx_ext   = {{IDX_BITS{1'b0}}, best_idx_reg};

    // stable rank compare: ties keep arrival order
    always_comb
    begin
        if (y_rd_reg == yi_reg)
            hit = (j_reg < i_reg);
        else if (desc_reg)
            hit = (y_rd_reg > yi_reg);
        else
            hit = (y_rd_reg < yi_reg);
    end

    // read port stays on the current point until ADV has latched it
    always_comb
    begin
        unique case (state_reg)
            ST_RANK_FETCH: pt_addr = i_reg[AW-1:0];
            ST_RANK_SCAN:  pt_addr = j_inc[AW-1:0];
            ST_SW_PT:      pt_addr = use_ord_reg ? ord_rd_reg : k_reg[AW-1:0];
            ST_SW_DAT, ST_SW_MUL, ST_SW_ACC:
                           pt_addr = pa_reg;
            default:       pt_addr = '0;
        endcase
    end

    // memories
    always_ff @(posedge clk)
    begin
        if (load_fire && (cnt_reg < CW'(MAX_POINTS)))
        begin
            x_mem[cnt_reg[AW-1:0]] <= in_data.point_x;
            y_mem[cnt_reg[AW-1:0]] <= in_data.point_y;
        end
        if (state_reg == ST_RANK_WRITE)
            ord_mem[rank_reg] <= i_reg[AW-1:0];
        x_rd_reg   <= x_mem[pt_addr];
        y_rd_reg   <= y_mem[pt_addr];
        ord_rd_reg <= ord_mem[k_reg[AW-1:0]];
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD:
                if (load_fire && in_data.last_point)
                    state_next = ST_DISPATCH;
            ST_DISPATCH:
            begin
                case (mode_reg)
                    MODE_TOTAL:
                        state_next = presort_reg ? ST_RANK_FETCH : ST_SW_ORD;
                    MODE_LEAST, MODE_GREATEST:
                        state_next = (n_reg < CW'(2)) ? ST_EMIT : ST_RANK_FETCH;
                    default:
                        state_next = ST_EMIT;
                endcase
            end
            ST_RANK_FETCH: state_next = ST_RANK_LATCH;
            ST_RANK_LATCH: state_next = ST_RANK_SCAN;
            ST_RANK_SCAN:  if (last_scan) state_next = ST_RANK_WRITE;
            ST_RANK_WRITE:
                state_next = (i_reg + CW'(1) == n_reg) ? ST_SW_ORD : ST_RANK_FETCH;
            ST_SW_ORD:     state_next = ST_SW_PT;
            ST_SW_PT:      state_next = ST_SW_DAT;
            ST_SW_DAT:     state_next = (k_reg == '0) ? ST_SW_ADV : ST_SW_MUL;
            ST_SW_MUL:     state_next = ST_SW_ACC;
            ST_SW_ACC:     state_next = fin_reg ? ST_EMIT : ST_SW_ADV;
            ST_SW_ADV:
                state_next = (k_reg + CW'(1) == n_reg) ? ST_SW_FIN : ST_SW_ORD;
            ST_SW_FIN:     state_next = ST_SW_MUL;
            ST_EMIT:
                if (!out_valid_reg || out_ready)
                    state_next = ST_LOAD;
            default:       state_next = ST_LOAD;
        endcase
    end

    // outputs
    always_comb
    begin
        in_ready  = (state_reg == ST_LOAD);
        cfg_ready = 1'b1;
        out_valid = out_valid_reg;
        out_data  = out_data_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            ref_x_reg     <= '0;
            ref_y_reg     <= '0;
            mode_reg      <= MODE_TOTAL;
            presort_reg   <= 1'b1;
            cnt_reg       <= '0;
            n_reg         <= '0;
            acc_reg       <= '0;
            best_value_reg <= '0;
            best_idx_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_REF_X:   ref_x_reg   <= cfg_data;
                    CFG_REF_Y:   ref_y_reg   <= cfg_data;
                    CFG_MODE:    mode_reg    <= cfg_data[1:0];
                    CFG_PRESORT: presort_reg <= cfg_data[0];
                    default:     ;
                endcase
            end

            if (load_fire)
            begin
                if (in_data.last_point)
                begin
                    cnt_reg <= '0;
                    n_reg   <= (cnt_reg < CW'(MAX_POINTS)) ? cnt_reg + CW'(1) : cnt_reg;
                end
                else if (cnt_reg < CW'(MAX_POINTS))
                    cnt_reg <= cnt_reg + CW'(1);
            end

            if (state_reg == ST_DISPATCH)
            begin
                acc_reg      <= '0;
                best_idx_reg <= '0;
            end

            if ((state_reg == ST_SW_ACC) && (mode_reg == MODE_TOTAL))
                acc_reg <= (sum > (VOL_BITS+1)'(VOL_MAX)) ? VOL_MAX : sum[VOL_BITS-1:0];

            if ((state_reg == ST_SW_ACC) && (mode_reg != MODE_TOTAL))
            begin
                if ((!fin_reg && (k_reg == CW'(1))) || better)
                begin
                    best_value_reg <= prod_reg;
                    best_idx_reg   <= pidx_reg;
                end
            end

            if ((state_reg == ST_EMIT) && (!out_valid_reg || out_ready))
            begin
                out_valid_reg <= 1'b1;
                out_data_reg.volume <= (mode_reg == MODE_TOTAL) ? acc_reg : '0;
                out_data_reg.contributor_index <=
                    ((mode_reg == MODE_LEAST) || (mode_reg == MODE_GREATEST))
                    ? idx_ext[IDX_BITS-1:0] : '0;
            end
            else if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // datapath without reset
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_DISPATCH:
            begin
                i_reg       <= '0;
                k_reg       <= '0;
                fin_reg     <= 1'b0;
                desc_reg    <= (mode_reg != MODE_TOTAL);
                use_ord_reg <= (mode_reg != MODE_TOTAL) || presort_reg;
            end
            ST_RANK_LATCH:
            begin
                yi_reg   <= y_rd_reg;
                j_reg    <= '0;
                rank_reg <= '0;
            end
            ST_RANK_SCAN:
            begin
                rank_reg <= rank_reg + AW'(hit);
                j_reg    <= j_inc;
            end
            ST_RANK_WRITE:
                i_reg <= i_reg + CW'(1);
            ST_SW_PT:
                pa_reg <= pt_addr;
            ST_SW_DAT:
            begin
                if (mode_reg == MODE_TOTAL)
                begin
                    opa_reg <= adiff(yp_reg, y_rd_reg);
                    opb_reg <= adiff(xp_reg, ref_x_reg);
                end
                else
                begin
                    opa_reg <= adiff(yp_reg, (k_reg == CW'(1)) ? ref_y_reg : yp2_reg);
                    opb_reg <= adiff(xp_reg, x_rd_reg);
                end
            end
            ST_SW_MUL:
                prod_reg <= opa_reg * opb_reg;
            ST_SW_ADV:
            begin
                yp2_reg  <= yp_reg;
                yp_reg   <= y_rd_reg;
                xp_reg   <= x_rd_reg;
                pidx_reg <= pa_reg;
                k_reg    <= k_reg + CW'(1);
            end
            ST_SW_FIN:
            begin
                fin_reg <= 1'b1;
                if (mode_reg == MODE_TOTAL)
                    opa_reg <= adiff(ref_y_reg, yp_reg);
                else
                    opa_reg <= adiff(yp_reg, yp2_reg);
                opb_reg <= adiff(ref_x_reg, xp_reg);
            end
            default: ;
        endcase
    end

    assert property (@(posedge clk) disable iff (!rst_n) cnt_reg <= CW'(MAX_POINTS))
        else $error("point count beyond store depth");
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RANK_WRITE) |-> (CW'(rank_reg) < n_reg))
        else $error("rank outside set");
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.volume != '0) |-> (out_data.contributor_index == '0))
        else $error("volume and index both set");
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SW_ACC) && fin_reg |=> (state_reg == ST_EMIT))
        else $error("sweep did not finish");
endmodule
